FILE: src/weighted_edge_list_table_top_assert.svh
// Assertion macros shared by the weighted edge list table RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef WEIGHTED_EDGE_LIST_TABLE_TOP_ASSERT_SVH
`define WEIGHTED_EDGE_LIST_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WELT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WELT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/welt_pkg.sv
// Package for the weighted edge list table: sizes, operation and status codes,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package welt_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    FUNC_ADD_EDGE      = 3'd0,
    FUNC_REMOVE_EDGE   = 3'd1,
    FUNC_REMOVE_VERTEX = 3'd2,
    FUNC_OFFSET_IDS    = 3'd3,
    FUNC_READ_ENTRY    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic purge;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic purge_pending;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/welt_ctrl.sv
// Controller state machine for the weighted edge list table.
// Depends on welt_pkg for the command and status structs.
`default_nettype none

module welt_ctrl import welt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire dp_stat_t  dp_stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_stat.purge_pending) begin
          cmd.purge = 1'b1;
        end else if (!dp_stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/welt_datapath.sv
// Datapath of the weighted edge list table: the row of edge cells, the edge count
// and the result register. Depends on welt_pkg and the assertion macro header.
`default_nettype none
`include "weighted_edge_list_table_top_assert.svh"

module welt_datapath import welt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                dp_stat,
  input  wire logic [2:0]         func,
  input  wire logic [15:0]        node_id,
  input  wire logic signed [15:0] edge_weight,
  input  wire logic signed [16:0] id_offset,
  input  wire logic [3:0]         entry_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [15:0]             neighbor_out,
  output logic signed [15:0]      weight_out,
  output logic [4:0]              edge_count
);

  logic [2:0]               func_r;
  logic [ID_BITS-1:0]       id_r;
  logic signed [15:0]       wt_r;
  logic signed [16:0]       off_r;
  logic [3:0]               idx_r;

  logic [ID_BITS-1:0]       ids_r [CAPACITY];
  logic [ID_BITS-1:0]       ids_nxt [CAPACITY];
  logic [15:0]              wts_r [CAPACITY];
  logic [15:0]              wts_nxt [CAPACITY];
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic [15:0]              nb_r, nb_nxt;
  logic [15:0]              wo_r, wo_nxt;
  logic [CNT_W-1:0]         cnt_out_r;

  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      first_hit;
  logic [CAPACITY-1:0]      at_or_after;
  logic                     any_match;
  logic [ID_BITS-1:0]       off_ext;
  logic [IDX_W-1:0]         idx_sel;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      match[k] = (CNT_W'(k) < count_r) && (ids_r[k] == id_r);
    end
  end

  // Isolate the lowest match, then mark it and every cell above it.
  assign first_hit   = match & (~match + CAPACITY'(1));
  assign at_or_after = ~(first_hit - CAPACITY'(1));
  assign any_match   = |match;
  assign off_ext     = ID_BITS'(off_r);
  assign idx_sel     = IDX_W'(idx_r);

  assign dp_stat.purge_pending = (func_r == FUNC_REMOVE_VERTEX) && any_match;
  assign dp_stat.out_busy      = out_valid_r && !out_ready;

  always_comb begin
    ids_nxt    = ids_r;
    wts_nxt    = wts_r;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    nb_nxt     = '0;
    wo_nxt     = '0;

    if (cmd.purge || (cmd.finish && (func_r == FUNC_REMOVE_EDGE) && any_match)) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (at_or_after[k]) begin
          ids_nxt[k] = ids_r[k + 1];
          wts_nxt[k] = wts_r[k + 1];
        end
      end
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd.finish) begin
      unique case (func_r)
        FUNC_ADD_EDGE: begin
          if (any_match) begin
            status_nxt = STAT_DUPLICATE;
          end else if (count_r == CAP_CNT) begin
            status_nxt = STAT_FULL;
          end else begin
            for (int k = 0; k < CAPACITY; k++) begin
              if (CNT_W'(k) == count_r) begin
                ids_nxt[k] = id_r;
                wts_nxt[k] = wt_r;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FUNC_REMOVE_EDGE: begin
          if (!any_match) begin
            status_nxt = STAT_NOT_FOUND;
          end
        end
        FUNC_REMOVE_VERTEX: begin
          for (int k = 0; k < CAPACITY; k++) begin
            if ((CNT_W'(k) < count_r) && (ids_r[k] > id_r)) begin
              ids_nxt[k] = ids_r[k] - ID_BITS'(1);
            end
          end
        end
        FUNC_OFFSET_IDS: begin
          for (int k = 0; k < CAPACITY; k++) begin
            ids_nxt[k] = ids_r[k] + off_ext;
          end
        end
        FUNC_READ_ENTRY: begin
          if (32'(idx_r) < 32'(count_r)) begin
            nb_nxt = 16'(ids_r[idx_sel]);
            wo_nxt = wts_r[idx_sel];
          end else begin
            status_nxt = STAT_BAD_INDEX;
          end
        end
        default: begin
          status_nxt = STAT_OK;
        end
      endcase
    end

    out_valid_nxt = cmd.finish || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ids_r <= ids_nxt;
    wts_r <= wts_nxt;
    if (cmd.load) begin
      func_r <= func;
      id_r   <= ID_BITS'(node_id);
      wt_r   <= edge_weight;
      off_r  <= id_offset;
      idx_r  <= entry_index;
    end
    if (cmd.finish) begin
      status_r  <= status_nxt;
      nb_r      <= nb_nxt;
      wo_r      <= wo_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign status       = 3'(status_r);
  assign neighbor_out = nb_r;
  assign weight_out   = wo_r;
  assign edge_count   = 5'(cnt_out_r);

  `WELT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CAP_CNT, "edge count above capacity")
  `WELT_ASSERT_SAME(a_purge_needs_match, cmd.purge, any_match, "purge step without a match")
  `WELT_ASSERT_NEXT(a_purge_shrinks, cmd.purge, count_r == $past(count_r) - CNT_W'(1),
    "purge step did not drop one edge")
  `WELT_ASSERT_SAME(a_finish_slot_free, cmd.finish, !(out_valid_r && !out_ready),
    "result written over a beat not yet taken")

endmodule

`default_nettype wire

FILE: src/weighted_edge_list_table_top.sv
// Channel    Dir  Width  Contents
// in_        in   56     func, node_id, edge_weight, id_offset, entry_index
// out_       out  40     status, neighbor_out, weight_out, edge_count
//
// One beat is taken while the controller is idle: a load step, then an execute step
// in the row of edge cells that waits while the last result is not taken. Removing a
// vertex adds a compaction per deleted edge; each cell compaction drops the first match.
// The result register frees the input side while a result waits on out_tready.
// Reset (rst_n low, synchronous) empties the table; stored entries keep no reset.
// Top level of the weighted edge list table; depends on welt_pkg, welt_ctrl, welt_datapath.
`default_nettype none

module weighted_edge_list_table_top import welt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: func[2:0], node_id[15:0], edge_weight[15:0],
  // id_offset[16:0], entry_index[3:0].
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: status[2:0], neighbor_out[15:0], weight_out[15:0],
  // edge_count[4:0].
  output logic [39:0]      out_tdata
);

  ctrl_cmd_t          cmd;
  dp_stat_t           dp_stat;
  logic [2:0]         status;
  logic [15:0]        neighbor_out;
  logic signed [15:0] weight_out;
  logic [4:0]         edge_count;

  welt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  welt_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .dp_stat      (dp_stat),
    .func         (in_tdata[2:0]),
    .node_id      (in_tdata[18:3]),
    .edge_weight  (in_tdata[34:19]),
    .id_offset    (in_tdata[51:35]),
    .entry_index  (in_tdata[55:52]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .status       (status),
    .neighbor_out (neighbor_out),
    .weight_out   (weight_out),
    .edge_count   (edge_count)
  );

  assign out_tdata = {edge_count, weight_out, neighbor_out, status};

endmodule

`default_nettype wire
